>>> design/kvi_pkg.sv
// -----------------------------------------------------------------------------
// kvi_pkg
// Shared types, codes and arithmetic helpers of the velocity integrator.
// -----------------------------------------------------------------------------
package kvi_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DAMP_BITS   = 16;
	localparam int SQRT_STEPS  = 32;
	localparam int DIV_STEPS   = 64;
	localparam int CNT_W       = 6;

	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_FORCE   = 3'd1;
	localparam logic [2:0] MODE_IMPULSE = 3'd2;
	localparam logic [2:0] MODE_VELFRC  = 3'd3;
	localparam logic [2:0] MODE_SETVEL  = 3'd4;

	localparam logic [1:0] KIND_CONT    = 2'd0;
	localparam logic [1:0] KIND_IMPULSE = 2'd1;
	localparam logic [1:0] KIND_VEL     = 2'd2;

	localparam logic [2:0] CFG_VLIMIT  = 3'd0;
	localparam logic [2:0] CFG_DAMP    = 3'd1;
	localparam logic [2:0] CFG_GRAV_ON = 3'd2;
	localparam logic [2:0] CFG_GRAV_X  = 3'd3;
	localparam logic [2:0] CFG_GRAV_Y  = 3'd4;
	localparam logic [2:0] CFG_DT      = 3'd5;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_FORCE, CMD_MUL_FDT, CMD_VEL, CMD_MUL_SQ, CMD_SUM,
		CMD_CMP, CMD_SQRT, CMD_MUL_MAG, CMD_DIV_INIT, CMD_DIV, CMD_QUOT,
		CMD_MUL_PDT, CMD_POS, CMD_MUL_DAMP, CMD_DAMP, CMD_OUT
	} kvi_cmd_t;

	typedef enum logic [4:0] {
		S_IDLE, S_FORCE, S_MUL_FDT, S_VEL, S_MUL_SQ, S_SUM, S_CMP, S_SQRT,
		S_MUL_MAG, S_DIV_INIT, S_DIV, S_QUOT, S_MUL_PDT, S_POS, S_MUL_DAMP,
		S_DAMP, S_DONE
	} kvi_state_t;

	typedef struct packed {
		kvi_cmd_t cmd;
	} kvi_ctrl_t;

	typedef struct packed {
		logic tick;
		logic over;
	} kvi_stat_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [66:0] hi;
		logic signed [66:0] lo;
		hi = 67'sh0_7FFF_FFFF;
		lo = -67'sh0_8000_0000;
		if (v > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
			input logic signed [65:0] b);
		logic signed [66:0] s;
		s = 67'(a) + 67'(b);
		add_sat = sat32(s);
	endfunction

endpackage

>>> design/kvi_ctrl.sv
// -----------------------------------------------------------------------------
// kvi_ctrl
// Sequencer of the integrator: steps the datapath through one item.
// -----------------------------------------------------------------------------
module kvi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  kvi_pkg::kvi_stat_t  stat,
	output kvi_pkg::kvi_ctrl_t  ctrl
);

	kvi_pkg::kvi_state_t state_q, state_d;
	logic [kvi_pkg::CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic slot_free;

	assign in_stall  = (state_q != kvi_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kvi_pkg::S_IDLE: begin
				if (in_valid) state_d = stat.tick ? kvi_pkg::S_FORCE : kvi_pkg::S_DONE;
			end
			kvi_pkg::S_FORCE:    state_d = kvi_pkg::S_MUL_FDT;
			kvi_pkg::S_MUL_FDT:  state_d = kvi_pkg::S_VEL;
			kvi_pkg::S_VEL:      state_d = kvi_pkg::S_MUL_SQ;
			kvi_pkg::S_MUL_SQ:   state_d = kvi_pkg::S_SUM;
			kvi_pkg::S_SUM:      state_d = kvi_pkg::S_CMP;
			kvi_pkg::S_CMP:      state_d = stat.over ? kvi_pkg::S_SQRT : kvi_pkg::S_MUL_PDT;
			kvi_pkg::S_SQRT: begin
				if (cnt_q == kvi_pkg::CNT_W'(kvi_pkg::SQRT_STEPS - 1))
					state_d = kvi_pkg::S_MUL_MAG;
			end
			kvi_pkg::S_MUL_MAG:  state_d = kvi_pkg::S_DIV_INIT;
			kvi_pkg::S_DIV_INIT: state_d = kvi_pkg::S_DIV;
			kvi_pkg::S_DIV: begin
				if (cnt_q == kvi_pkg::CNT_W'(kvi_pkg::DIV_STEPS - 1))
					state_d = kvi_pkg::S_QUOT;
			end
			kvi_pkg::S_QUOT:     state_d = kvi_pkg::S_MUL_PDT;
			kvi_pkg::S_MUL_PDT:  state_d = kvi_pkg::S_POS;
			kvi_pkg::S_POS:      state_d = kvi_pkg::S_MUL_DAMP;
			kvi_pkg::S_MUL_DAMP: state_d = kvi_pkg::S_DAMP;
			kvi_pkg::S_DAMP:     state_d = kvi_pkg::S_DONE;
			kvi_pkg::S_DONE: begin
				if (slot_free) state_d = kvi_pkg::S_IDLE;
			end
			default:             state_d = kvi_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.cmd = kvi_pkg::CMD_NONE;
		unique case (state_q)
			kvi_pkg::S_IDLE:     if (in_valid) ctrl.cmd = kvi_pkg::CMD_LOAD;
			kvi_pkg::S_FORCE:    ctrl.cmd = kvi_pkg::CMD_FORCE;
			kvi_pkg::S_MUL_FDT:  ctrl.cmd = kvi_pkg::CMD_MUL_FDT;
			kvi_pkg::S_VEL:      ctrl.cmd = kvi_pkg::CMD_VEL;
			kvi_pkg::S_MUL_SQ:   ctrl.cmd = kvi_pkg::CMD_MUL_SQ;
			kvi_pkg::S_SUM:      ctrl.cmd = kvi_pkg::CMD_SUM;
			kvi_pkg::S_CMP:      ctrl.cmd = kvi_pkg::CMD_CMP;
			kvi_pkg::S_SQRT:     ctrl.cmd = kvi_pkg::CMD_SQRT;
			kvi_pkg::S_MUL_MAG:  ctrl.cmd = kvi_pkg::CMD_MUL_MAG;
			kvi_pkg::S_DIV_INIT: ctrl.cmd = kvi_pkg::CMD_DIV_INIT;
			kvi_pkg::S_DIV:      ctrl.cmd = kvi_pkg::CMD_DIV;
			kvi_pkg::S_QUOT:     ctrl.cmd = kvi_pkg::CMD_QUOT;
			kvi_pkg::S_MUL_PDT:  ctrl.cmd = kvi_pkg::CMD_MUL_PDT;
			kvi_pkg::S_POS:      ctrl.cmd = kvi_pkg::CMD_POS;
			kvi_pkg::S_MUL_DAMP: ctrl.cmd = kvi_pkg::CMD_MUL_DAMP;
			kvi_pkg::S_DAMP:     ctrl.cmd = kvi_pkg::CMD_DAMP;
			kvi_pkg::S_DONE:     if (slot_free) ctrl.cmd = kvi_pkg::CMD_OUT;
			default:             ctrl.cmd = kvi_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kvi_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == kvi_pkg::S_SQRT || state_q == kvi_pkg::S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (ctrl.cmd == kvi_pkg::CMD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/kvi_datapath.sv
// -----------------------------------------------------------------------------
// kvi_datapath
// Registers, two multiplier lanes, square root and dividers of the integrator.
// -----------------------------------------------------------------------------
module kvi_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  kvi_pkg::kvi_ctrl_t  ctrl,
	output kvi_pkg::kvi_stat_t  stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [2:0]          mode,
	input  logic signed [31:0]  vec_x,
	input  logic signed [31:0]  vec_y,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	output logic signed [31:0]  new_pos_x,
	output logic signed [31:0]  new_pos_y,
	output logic signed [31:0]  speed_x,
	output logic signed [31:0]  speed_y
);

	logic [30:0]        vlimit_q;
	logic [16:0]        damp_q;
	logic               grav_on_q;
	logic signed [31:0] grav_q [2];
	logic [16:0]        dt_q;

	logic signed [31:0] vel_q [2];
	logic signed [31:0] force_q [2];
	logic [1:0]         kind_q;

	logic signed [31:0] f_q [2];
	logic signed [31:0] v_q [2];
	logic signed [31:0] pos_q [2];
	logic signed [31:0] npos_q [2];
	logic signed [65:0] prod_q [2];
	logic [63:0]        sum_q;
	logic [63:0]        sq_n_q;
	logic [32:0]        sq_rem_q;
	logic [31:0]        root_q;
	logic [31:0]        div_rem_q [2];
	logic [63:0]        div_q_q [2];
	logic signed [31:0] out_q [4];

	logic signed [31:0] vec_in [2];
	logic signed [31:0] pos_in [2];
	logic signed [32:0] op_a [2];
	logic signed [32:0] op_b [2];
	logic signed [65:0] mul_r [2];
	logic [32:0]        mag [2];
	logic [34:0]        sq_cat;
	logic [34:0]        sq_trial;
	logic [34:0]        sq_diff;
	logic [32:0]        div_t [2];
	logic [32:0]        div_d [2];
	logic               do_mul;

	assign vec_in[0] = vec_x;
	assign vec_in[1] = vec_y;
	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;

	assign new_pos_x = out_q[0];
	assign new_pos_y = out_q[1];
	assign speed_x   = out_q[2];
	assign speed_y   = out_q[3];

	assign stat.tick = (mode == kvi_pkg::MODE_TICK);
	assign stat.over = (sum_q > prod_q[0][63:0]);

	assign do_mul = (ctrl.cmd == kvi_pkg::CMD_MUL_FDT) || (ctrl.cmd == kvi_pkg::CMD_MUL_SQ)
		|| (ctrl.cmd == kvi_pkg::CMD_SUM) || (ctrl.cmd == kvi_pkg::CMD_MUL_MAG)
		|| (ctrl.cmd == kvi_pkg::CMD_MUL_PDT) || (ctrl.cmd == kvi_pkg::CMD_MUL_DAMP);

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mag[i] = v_q[i][31] ? (33'd0 - {v_q[i][31], v_q[i]}) : {1'b0, v_q[i]};
			unique case (ctrl.cmd)
				kvi_pkg::CMD_MUL_FDT: begin
					op_a[i] = 33'(f_q[i]);
					op_b[i] = $signed({16'd0, dt_q});
				end
				kvi_pkg::CMD_MUL_SQ: begin
					op_a[i] = 33'(v_q[i]);
					op_b[i] = 33'(v_q[i]);
				end
				kvi_pkg::CMD_SUM: begin
					op_a[i] = $signed({2'd0, vlimit_q});
					op_b[i] = $signed({2'd0, vlimit_q});
				end
				kvi_pkg::CMD_MUL_MAG: begin
					op_a[i] = $signed(mag[i]);
					op_b[i] = $signed({2'd0, vlimit_q});
				end
				kvi_pkg::CMD_MUL_PDT: begin
					op_a[i] = 33'(v_q[i]);
					op_b[i] = $signed({16'd0, dt_q});
				end
				kvi_pkg::CMD_MUL_DAMP: begin
					op_a[i] = 33'(v_q[i]);
					op_b[i] = $signed({16'd0, damp_q});
				end
				default: begin
					op_a[i] = '0;
					op_b[i] = '0;
				end
			endcase
			mul_r[i] = op_a[i] * op_b[i];
			div_t[i] = {div_rem_q[i], div_q_q[i][63]};
			div_d[i] = div_t[i] - {1'b0, root_q};
		end
		sq_cat   = {sq_rem_q, sq_n_q[63:62]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_diff  = sq_cat - sq_trial;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlimit_q  <= 31'd655360;
			damp_q    <= 17'd65536;
			grav_on_q <= 1'b0;
			grav_q[0] <= '0;
			grav_q[1] <= '0;
			dt_q      <= 17'd1092;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kvi_pkg::CFG_VLIMIT:  vlimit_q  <= cfg_data[30:0];
				kvi_pkg::CFG_DAMP:    damp_q    <= cfg_data[16:0];
				kvi_pkg::CFG_GRAV_ON: grav_on_q <= cfg_data[0];
				kvi_pkg::CFG_GRAV_X:  grav_q[0] <= cfg_data;
				kvi_pkg::CFG_GRAV_Y:  grav_q[1] <= cfg_data;
				kvi_pkg::CFG_DT:      dt_q      <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Body state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				vel_q[i]   <= '0;
				force_q[i] <= '0;
			end
			kind_q <= kvi_pkg::KIND_CONT;
		end else begin
			if (ctrl.cmd == kvi_pkg::CMD_LOAD) begin
				if (mode == kvi_pkg::MODE_FORCE || mode == kvi_pkg::MODE_IMPULSE) begin
					kind_q <= (mode == kvi_pkg::MODE_FORCE) ? kvi_pkg::KIND_CONT
						: kvi_pkg::KIND_IMPULSE;
					force_q[0] <= vec_x;
					force_q[1] <= vec_y;
				end else if (mode == kvi_pkg::MODE_VELFRC) begin
					kind_q     <= kvi_pkg::KIND_VEL;
					force_q[0] <= '0;
					force_q[1] <= '0;
					vel_q[0]   <= vec_x;
					vel_q[1]   <= vec_y;
				end else if (mode == kvi_pkg::MODE_SETVEL) begin
					vel_q[0] <= vec_x;
					vel_q[1] <= vec_y;
				end
			end
			if (ctrl.cmd == kvi_pkg::CMD_DAMP) begin
				for (int i = 0; i < 2; i++) begin
					vel_q[i] <= kvi_pkg::sat32(67'(prod_q[i] >>> kvi_pkg::DAMP_BITS));
					if (kind_q == kvi_pkg::KIND_IMPULSE) force_q[i] <= '0;
				end
			end
		end
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		if (do_mul) begin
			for (int i = 0; i < 2; i++) prod_q[i] <= mul_r[i];
		end
		unique case (ctrl.cmd)
			kvi_pkg::CMD_LOAD: begin
				for (int i = 0; i < 2; i++) begin
					pos_q[i]  <= pos_in[i];
					npos_q[i] <= pos_in[i];
				end
			end
			kvi_pkg::CMD_FORCE: begin
				for (int i = 0; i < 2; i++) begin
					f_q[i] <= grav_on_q ? kvi_pkg::add_sat(force_q[i], 66'(grav_q[i]))
						: force_q[i];
				end
			end
			kvi_pkg::CMD_VEL: begin
				for (int i = 0; i < 2; i++)
					v_q[i] <= kvi_pkg::add_sat(vel_q[i], prod_q[i] >>> kvi_pkg::FRAC_BITS);
			end
			kvi_pkg::CMD_SUM: begin
				sum_q <= prod_q[0][63:0] + prod_q[1][63:0];
			end
			kvi_pkg::CMD_CMP: begin
				sq_n_q   <= sum_q;
				sq_rem_q <= '0;
				root_q   <= '0;
			end
			kvi_pkg::CMD_SQRT: begin
				sq_n_q <= {sq_n_q[61:0], 2'b00};
				if (sq_cat >= sq_trial) begin
					sq_rem_q <= sq_diff[32:0];
					root_q   <= {root_q[30:0], 1'b1};
				end else begin
					sq_rem_q <= sq_cat[32:0];
					root_q   <= {root_q[30:0], 1'b0};
				end
			end
			kvi_pkg::CMD_DIV_INIT: begin
				for (int i = 0; i < 2; i++) begin
					div_rem_q[i] <= '0;
					div_q_q[i]   <= prod_q[i][63:0];
				end
			end
			kvi_pkg::CMD_DIV: begin
				for (int i = 0; i < 2; i++) begin
					if (div_t[i] >= {1'b0, root_q}) begin
						div_rem_q[i] <= div_d[i][31:0];
						div_q_q[i]   <= {div_q_q[i][62:0], 1'b1};
					end else begin
						div_rem_q[i] <= div_t[i][31:0];
						div_q_q[i]   <= {div_q_q[i][62:0], 1'b0};
					end
				end
			end
			kvi_pkg::CMD_QUOT: begin
				for (int i = 0; i < 2; i++)
					v_q[i] <= v_q[i][31] ? (32'd0 - div_q_q[i][31:0]) : div_q_q[i][31:0];
			end
			kvi_pkg::CMD_POS: begin
				for (int i = 0; i < 2; i++)
					npos_q[i] <= kvi_pkg::add_sat(pos_q[i], prod_q[i] >>> kvi_pkg::FRAC_BITS);
			end
			kvi_pkg::CMD_OUT: begin
				out_q[0] <= npos_q[0];
				out_q[1] <= npos_q[1];
				out_q[2] <= vel_q[0];
				out_q[3] <= vel_q[1];
			end
			default: ;
		endcase
	end

endmodule

>>> design/kinematic_velocity_integrator_top.sv
// -----------------------------------------------------------------------------
// kinematic_velocity_integrator_top
// Semi-implicit Euler integrator of one 2D body in Q16.16 fixed point.
// -----------------------------------------------------------------------------
// Usage: an input item (mode, vec, pos) is taken when in_valid is high and
// in_stall low. Modes 1 to 4 load a force, an impulse, a velocity-type force
// or a velocity. A tick (mode 0) runs the sequencer through force, velocity,
// magnitude check, position update and velocity damping. When the speed
// limit is exceeded, a square root unit retiring one result bit a cycle
// and two restoring dividers retiring one quotient bit a cycle rescale the
// velocity before the position update.
// The block works on one item at a time; in_stall is high from acceptance
// until the result has been written to the output register. The result item
// waits there, with out_valid high, for as long as out_stall is held, and the
// next input item may already be accepted meanwhile. A finished item that
// finds the output register still full waits in the sequencer.
// Configuration writes (cfg_we, cfg_index, cfg_data) act at once; the user is
// to make them only while the block is idle, which the block does not enforce.
// Reset restores the register defaults and clears velocity, force and force kind; no result is pending after reset.
// -----------------------------------------------------------------------------
module kinematic_velocity_integrator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] speed_x,
	output logic signed [31:0] speed_y
);

	kvi_pkg::kvi_ctrl_t ctrl;
	kvi_pkg::kvi_stat_t stat;

	kvi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	kvi_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.new_pos_x (new_pos_x),
		.new_pos_y (new_pos_y),
		.speed_x   (speed_x),
		.speed_y   (speed_y)
	);

	// Once an item is taken, the block is busy on the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block not busy after taking an item");

	// A new result only appears at the end of an item's processing.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without an item in progress");

	// The sequencer only writes the output register while it has room.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> (ctrl.cmd != kvi_pkg::CMD_OUT))
		else $error("output register overwritten while stalled");

endmodule

>>> dv/kinematic_velocity_integrator_top_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kinematic_velocity_integrator_top_tb
// Self-checking bench for the 2D velocity integrator. Items are sent through
// the valid/stall handshake with random idling on both sides, a behavioural
// model of the integrator predicts every result, and each result item is
// compared field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module kinematic_velocity_integrator_top_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
	} motion_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         mode;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] new_pos_x;
	logic signed [31:0] new_pos_y;
	logic signed [31:0] speed_x;
	logic signed [31:0] speed_y;

	// Shadow of the configuration registers and of the body's state.
	logic [30:0]        lim_q;
	logic [16:0]        damp_q;
	logic               grav_on_q;
	logic signed [31:0] grav_x_q;
	logic signed [31:0] grav_y_q;
	logic [16:0]        dt_q;
	logic signed [31:0] vel_x_q;
	logic signed [31:0] vel_y_q;
	logic signed [31:0] frc_x_q;
	logic signed [31:0] frc_y_q;
	logic [1:0]         kind_q;

	motion_t expected_motion[$];
	int      fail_count;
	int      idle_cycles;
	bit      calm;

	kinematic_velocity_integrator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .vec_x(vec_x), .vec_y(vec_y), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_pos_x(new_pos_x), .new_pos_y(new_pos_y),
		.speed_x(speed_x), .speed_y(speed_y)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Clip a wide signed value into the 32-bit range.
	function automatic logic signed [31:0] clip32(input logic signed [95:0] v);
		if (v > 96'sh7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -96'sh8000_0000) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// The arithmetic shift of a signed value rounds toward minus infinity.
	function automatic logic signed [95:0] scaled(input logic signed [31:0] a,
			input logic [16:0] b);
		logic signed [95:0] p;
		p = 96'(a) * $signed({79'd0, b});
		return p >>> 16;
	endfunction

	// Magnitude times limit over length, truncated toward zero.
	function automatic logic signed [31:0] rescale(input logic signed [31:0] v,
			input logic [63:0] len);
		logic [63:0]  mag;
		logic [127:0] q;
		mag = (v < 0) ? 64'(-64'(v)) : 64'(v);
		q = (128'(mag) * 128'(lim_q)) / 128'(len);
		return (v < 0) ? clip32(-$signed(96'(q))) : clip32($signed(96'(q)));
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Advances the shadow state by one item and returns the motion it yields.
	function automatic motion_t integrate(input logic [2:0] m,
			input logic signed [31:0] vx_in, input logic signed [31:0] vy_in,
			input logic signed [31:0] px, input logic signed [31:0] py);
		motion_t            r;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [63:0]        mag_sq;
		logic [63:0]        len;
		r.px = px;
		r.py = py;
		case (m)
			kvi_pkg::MODE_TICK: begin
				fx = frc_x_q;
				fy = frc_y_q;
				if (grav_on_q) begin
					fx = clip32(96'(fx) + 96'(grav_x_q));
					fy = clip32(96'(fy) + 96'(grav_y_q));
				end
				vx = clip32(96'(vel_x_q) + scaled(fx, dt_q));
				vy = clip32(96'(vel_y_q) + scaled(fy, dt_q));
				mag_sq = 64'($signed(64'(vx)) * $signed(64'(vx)))
					+ 64'($signed(64'(vy)) * $signed(64'(vy)));
				if (mag_sq > 64'(lim_q) * 64'(lim_q)) begin
					len = floor_sqrt(mag_sq);
					vx = rescale(vx, len);
					vy = rescale(vy, len);
				end
				r.px = clip32(96'(px) + scaled(vx, dt_q));
				r.py = clip32(96'(py) + scaled(vy, dt_q));
				vel_x_q = clip32(scaled(vx, damp_q));
				vel_y_q = clip32(scaled(vy, damp_q));
				if (kind_q == kvi_pkg::KIND_IMPULSE) begin
					frc_x_q = 0;
					frc_y_q = 0;
				end
			end
			kvi_pkg::MODE_FORCE, kvi_pkg::MODE_IMPULSE: begin
				kind_q  = (m == kvi_pkg::MODE_FORCE) ? kvi_pkg::KIND_CONT
					: kvi_pkg::KIND_IMPULSE;
				frc_x_q = vx_in;
				frc_y_q = vy_in;
			end
			kvi_pkg::MODE_VELFRC: begin
				kind_q  = kvi_pkg::KIND_VEL;
				frc_x_q = 0;
				frc_y_q = 0;
				vel_x_q = vx_in;
				vel_y_q = vy_in;
			end
			kvi_pkg::MODE_SETVEL: begin
				vel_x_q = vx_in;
				vel_y_q = vy_in;
			end
			default: ;
		endcase
		r.sx = vel_x_q;
		r.sy = vel_y_q;
		return r;
	endfunction

	// Sends one item, idling beforehand now and then, and records its result.
	// The block is always busy in the cycle after it takes an item, so the
	// sender drops valid for that cycle without losing any throughput.
	task automatic send_item(input logic [2:0] m, input logic signed [31:0] vx,
			input logic signed [31:0] vy, input logic signed [31:0] px,
			input logic signed [31:0] py);
		while (!calm && $urandom_range(99) < 21) @(posedge clk);
		in_valid <= 1'b1;
		mode     <= m;
		vec_x    <= vx;
		vec_y    <= vy;
		pos_x    <= px;
		pos_y    <= py;
		expected_motion.push_back(integrate(m, vx, vy, px, py));
		@(posedge clk);
		while (in_stall) @(posedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Lets every expected result arrive, then lets the sequencer settle.
	task automatic drain();
		while (expected_motion.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// Drives one register write; the caller drops the write enable afterwards.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			kvi_pkg::CFG_VLIMIT:  lim_q     = val[30:0];
			kvi_pkg::CFG_DAMP:    damp_q    = val[16:0];
			kvi_pkg::CFG_GRAV_ON: grav_on_q = val[0];
			kvi_pkg::CFG_GRAV_X:  grav_x_q  = val;
			kvi_pkg::CFG_GRAV_Y:  grav_y_q  = val;
			kvi_pkg::CFG_DT:      dt_q      = val[16:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [31:0] l, input logic [31:0] d,
			input logic [31:0] g, input logic [31:0] gx, input logic [31:0] gy,
			input logic [31:0] t);
		drain();
		write_reg(kvi_pkg::CFG_VLIMIT, l);
		write_reg(kvi_pkg::CFG_DAMP, d);
		write_reg(kvi_pkg::CFG_GRAV_ON, g);
		write_reg(kvi_pkg::CFG_GRAV_X, gx);
		write_reg(kvi_pkg::CFG_GRAV_Y, gy);
		write_reg(kvi_pkg::CFG_DT, t);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rnd_val();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed(32'($urandom_range(1 << 21))) - 32'sd1048576;
			2: return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed(32'($urandom_range(1 << 17))) - 32'sd65536;
		endcase
	endfunction

	// Extremes of every field, every mode and the named corner cases.
	task automatic test_directed();
		send_item(kvi_pkg::MODE_TICK, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_item(kvi_pkg::MODE_FORCE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
		send_item(kvi_pkg::MODE_TICK, 0, 0, 32'sh7FFF_0000, -32'sh7FFF_0000);
		send_item(kvi_pkg::MODE_IMPULSE, 32'sh0010_0000, -32'sh0020_0000, 1, -1);
		send_item(kvi_pkg::MODE_TICK, -1, -1, 0, 0);
		send_item(kvi_pkg::MODE_TICK, 0, 0, 0, 0);
		send_item(kvi_pkg::MODE_VELFRC, 32'sh0030_0000, 32'sh0040_0000, 5, 5);
		send_item(kvi_pkg::MODE_TICK, 0, 0, 0, 0);
		send_item(kvi_pkg::MODE_SETVEL, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
		send_item(kvi_pkg::MODE_TICK, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_item(3'd5, 32'sh1234_5678, 1, 7, 8);
		send_item(3'd6, 0, 0, -7, -8);
		send_item(3'd7, -1, -1, 32'sh7FFF_FFFF, 0);
		set_all(32'h7FFF_FFFF, 32'd131071, 1, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'd65536);
		send_item(kvi_pkg::MODE_SETVEL, 32'sh4000_0000, -32'sh4000_0000, 0, 0);
		send_item(kvi_pkg::MODE_TICK, 0, 0, 100, -100);
		send_item(kvi_pkg::MODE_TICK, 0, 0, 0, 0);
		set_all(0, 0, 0, 0, 0, 0);
		send_item(kvi_pkg::MODE_FORCE, 32'sh0100_0000, 32'sh0100_0000, 0, 0);
		send_item(kvi_pkg::MODE_SETVEL, 32'sh0001_0000, 0, 0, 0);
		send_item(kvi_pkg::MODE_TICK, 0, 0, 3, 4);
		set_all(1, 65536, 1, -32'sh0001_0000, 32'sh0002_0000, 1);
		send_item(kvi_pkg::MODE_TICK, 0, 0, 0, 0);
	endtask

	// Random sequences: mostly ticks, mixed with loads and now and then an unused mode.
	task automatic test_random(input int count);
		logic [2:0] m;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 55) begin
				m = kvi_pkg::MODE_TICK;
			end else if ($urandom_range(99) < 8) begin
				m = 3'($urandom_range(7, 5));
			end else begin
				m = 3'($urandom_range(4, 1));
			end
			send_item(m, rnd_val(), rnd_val(), rnd_val(), rnd_val());
		end
	endtask

	task automatic test_configs();
		set_all(655360, 65536, 0, 0, 0, 1092);
		test_random(300);
		set_all(32'($urandom_range(1 << 24)), 32'($urandom_range(65536)), 1,
			rnd_val(), rnd_val(), 32'($urandom_range(65536, 1)));
		test_random(300);
		// A quiet stretch with no idling on either side.
		calm = 1'b1;
		test_random(250);
		calm = 1'b0;
		set_all(32'h7FFF_FFFF, 65536, 1, 32'sh0000_8000, -32'sh0000_8000, 65536);
		test_random(250);
		set_all(32'($urandom), 32'($urandom_range(131071)), 1, rnd_val(),
			rnd_val(), 32'($urandom_range(131071)));
		test_random(300);
	endtask

	// Receiver: random stalls except during the quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 21);
		end
	end

	// Compares each accepted result with the oldest prediction.
	always @(posedge clk) begin
		motion_t exp_m;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_motion.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %h", $time,
					new_pos_x, new_pos_y, speed_x, speed_y);
				fail_count++;
			end else begin
				exp_m = expected_motion.pop_front();
				if (new_pos_x !== exp_m.px) begin
					$display("%0t: new_pos_x expected %h actual %h", $time,
						exp_m.px, new_pos_x);
					fail_count++;
				end
				if (new_pos_y !== exp_m.py) begin
					$display("%0t: new_pos_y expected %h actual %h", $time,
						exp_m.py, new_pos_y);
					fail_count++;
				end
				if (speed_x !== exp_m.sx) begin
					$display("%0t: speed_x expected %h actual %h", $time,
						exp_m.sx, speed_x);
					fail_count++;
				end
				if (speed_y !== exp_m.sy) begin
					$display("%0t: speed_y expected %h actual %h", $time,
						exp_m.sy, speed_y);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither side accepts an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; mode = '0;
		vec_x = '0; vec_y = '0; pos_x = '0; pos_y = '0;
		fail_count = 0; idle_cycles = 0; calm = 1'b0;
		lim_q = 31'd655360; damp_q = 17'd65536; grav_on_q = 1'b0;
		grav_x_q = 0; grav_y_q = 0; dt_q = 17'd1092;
		vel_x_q = 0; vel_y_q = 0; frc_x_q = 0; frc_y_q = 0;
		kind_q = kvi_pkg::KIND_CONT;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_configs();
		drain();
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
